// ----- rtl/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg
// shared constants, types and the signed compare for the run merge sorter
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ELEMS);
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int DATA_W    = 32;
  localparam int RS_W      = 7;
  localparam int RS_RESET  = 32;
  localparam int WID_W     = (RS_W > CNT_W) ? RS_W : CNT_W;
  localparam int SUM_W     = WID_W + 2;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } load_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] n;
    logic [RS_W-1:0]  rs;
  } sort_cmd_t;

  function automatic logic sgt(input logic signed [DATA_W-1:0] a,
                               input logic signed [DATA_W-1:0] b);
    return a > b;
  endfunction

endpackage

// ----- rtl/rms_core.sv -----
// ----------------------------------------------------------------------------
// rms_core
// element store, merge scratch and the sequencer that sorts and emits a set
// ----------------------------------------------------------------------------
module rms_core (
  input  logic                             clk,
  input  logic                             rst,
  input  rms_pkg::load_t                   load,
  input  rms_pkg::sort_cmd_t               cmd,
  output logic                             busy,
  output logic                             result_valid,
  output logic signed [rms_pkg::DATA_W-1:0] sorted_value,
  output logic                             last_out
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_RUN_START  = 4'd1;
  localparam logic [3:0] S_INS_CHK    = 4'd2;
  localparam logic [3:0] S_INS_KEY    = 4'd3;
  localparam logic [3:0] S_INS_RD     = 4'd4;
  localparam logic [3:0] S_INS_CMP    = 4'd5;
  localparam logic [3:0] S_INS_PUT    = 4'd6;
  localparam logic [3:0] S_PASS_CHK   = 4'd7;
  localparam logic [3:0] S_PAIR_START = 4'd8;
  localparam logic [3:0] S_MRG_RD     = 4'd9;
  localparam logic [3:0] S_MRG_CMP    = 4'd10;
  localparam logic [3:0] S_CPY_RD     = 4'd11;
  localparam logic [3:0] S_CPY_WR     = 4'd12;
  localparam logic [3:0] S_OUT_RD     = 4'd13;
  localparam logic [3:0] S_OUT_EMIT   = 4'd14;

  localparam int CW = rms_pkg::CNT_W;
  localparam int AW = rms_pkg::ADDR_W;
  localparam int DW = rms_pkg::DATA_W;
  localparam int WW = rms_pkg::WID_W;
  localparam int SW = rms_pkg::SUM_W;

  logic [3:0] state;

  logic signed [DW-1:0] element_store [rms_pkg::MAX_ELEMS];
  logic signed [DW-1:0] merge_scratch [rms_pkg::MAX_ELEMS];
  logic signed [DW-1:0] rd_a;
  logic signed [DW-1:0] rd_b;
  logic signed [DW-1:0] sc_rd;

  logic                 st_we;
  logic [AW-1:0]        st_waddr;
  logic signed [DW-1:0] st_wdata;
  logic [AW-1:0]        ra;
  logic [AW-1:0]        rb;
  logic                 sc_we;
  logic [AW-1:0]        sc_waddr;
  logic signed [DW-1:0] sc_wdata;
  logic [AW-1:0]        sc_raddr;

  logic [CW-1:0]          n;
  logic [rms_pkg::RS_W-1:0] rs;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [CW-1:0]          i;
  logic [CW-1:0]          j;
  logic [CW-1:0]          k;
  logic [CW-1:0]          a;
  logic [CW-1:0]          b;
  logic [CW-1:0]          left;
  logic [CW-1:0]          mid;
  logic [CW-1:0]          right;
  logic [WW-1:0]          width;
  logic signed [DW-1:0]   key;

  logic [CW-1:0]        jm1;
  logic [CW-1:0]        k_inc;
  logic [SW-1:0]        run_sum;
  logic [CW-1:0]        run_end;
  logic [SW-1:0]        mid_sum;
  logic [SW-1:0]        right_sum;
  logic [CW-1:0]        pair_mid;
  logic [CW-1:0]        pair_right;
  logic signed [DW-1:0] cmp_b;
  logic                 cmp_gt;
  logic                 take_a;

  // shared compare unit
  assign cmp_b  = (state == S_INS_CMP) ? key : rd_b;
  assign cmp_gt = rms_pkg::sgt(rd_a, cmp_b);
  assign take_a = (a < mid) && ((b >= right) || !cmp_gt);

  assign jm1   = j - 1'b1;
  assign k_inc = k + 1'b1;

  assign run_sum    = SW'(lo) + SW'(rs);
  assign run_end    = (run_sum >= SW'(n)) ? n : run_sum[CW-1:0];
  assign mid_sum    = SW'(left) + SW'(width);
  assign right_sum  = SW'(left) + (SW'(width) << 1);
  assign pair_mid   = (mid_sum >= SW'(n)) ? n : mid_sum[CW-1:0];
  assign pair_right = (right_sum >= SW'(n)) ? n : right_sum[CW-1:0];

  always_comb begin
    st_we    = 1'b0;
    st_waddr = j[AW-1:0];
    st_wdata = key;
    ra       = i[AW-1:0];
    rb       = b[AW-1:0];
    sc_we    = 1'b0;
    sc_waddr = k[AW-1:0];
    sc_wdata = take_a ? rd_a : rd_b;
    sc_raddr = k[AW-1:0];
    unique case (state)
      S_IDLE: begin
        st_we    = load.we;
        st_waddr = load.addr;
        st_wdata = load.data;
      end
      S_INS_RD: begin
        ra = jm1[AW-1:0];
      end
      S_INS_CMP: begin
        st_we    = 1'b1;
        st_wdata = cmp_gt ? rd_a : key;
      end
      S_INS_PUT: begin
        st_we = 1'b1;
      end
      S_MRG_RD: begin
        ra = a[AW-1:0];
      end
      S_MRG_CMP: begin
        sc_we = 1'b1;
      end
      S_CPY_WR: begin
        st_we    = 1'b1;
        st_waddr = k[AW-1:0];
        st_wdata = sc_rd;
      end
      S_OUT_RD: begin
        ra = k[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      element_store[st_waddr] <= st_wdata;
    end
    rd_a <= element_store[ra];
    rd_b <= element_store[rb];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      merge_scratch[sc_waddr] <= sc_wdata;
    end
    sc_rd <= merge_scratch[sc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.go) begin
            n     <= cmd.n;
            rs    <= cmd.rs;
            lo    <= '0;
            state <= S_RUN_START;
          end
        end
        S_RUN_START: begin
          if (lo < n) begin
            hi    <= run_end;
            i     <= lo + 1'b1;
            state <= S_INS_CHK;
          end else begin
            width <= WW'(rs);
            state <= S_PASS_CHK;
          end
        end
        S_INS_CHK: begin
          if (i < hi) begin
            state <= S_INS_KEY;
          end else begin
            lo    <= hi;
            state <= S_RUN_START;
          end
        end
        S_INS_KEY: begin
          key   <= rd_a;
          j     <= i;
          state <= S_INS_RD;
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmp_gt) begin
            j     <= jm1;
            state <= (jm1 == lo) ? S_INS_PUT : S_INS_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_INS_CHK;
          end
        end
        S_INS_PUT: begin
          i     <= i + 1'b1;
          state <= S_INS_CHK;
        end
        S_PASS_CHK: begin
          if (width < WW'(n)) begin
            left  <= '0;
            state <= S_PAIR_START;
          end else begin
            k     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_PAIR_START: begin
          if (left < n) begin
            mid   <= pair_mid;
            right <= pair_right;
            if (pair_mid < pair_right) begin
              a     <= left;
              b     <= pair_mid;
              k     <= left;
              state <= S_MRG_RD;
            end else begin
              left <= pair_right;
            end
          end else begin
            width <= width << 1;
            state <= S_PASS_CHK;
          end
        end
        S_MRG_RD: begin
          state <= S_MRG_CMP;
        end
        S_MRG_CMP: begin
          if (take_a) begin
            a <= a + 1'b1;
          end else begin
            b <= b + 1'b1;
          end
          if (k_inc == right) begin
            k     <= left;
            state <= S_CPY_RD;
          end else begin
            k     <= k_inc;
            state <= S_MRG_RD;
          end
        end
        S_CPY_RD: begin
          state <= S_CPY_WR;
        end
        S_CPY_WR: begin
          if (k_inc == right) begin
            left  <= right;
            state <= S_PAIR_START;
          end else begin
            k     <= k_inc;
            state <= S_CPY_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (k_inc == n) begin
            state <= S_IDLE;
          end else begin
            k     <= k_inc;
            state <= S_OUT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT_EMIT);
  assign sorted_value = rd_a;
  assign last_out     = result_valid && (k_inc == n);

endmodule

// ----- rtl/run_merge_sort.sv -----
// ----------------------------------------------------------------------------
// run_merge_sort
// ascending stable sort of up to 64 signed 32-bit elements per set
// ----------------------------------------------------------------------------
// Elements load one per cycle while busy is low: one transaction each. The
// transaction marked last_in starts the sort, and busy stays high until the
// cycle after the final result. Runs of run_size elements are insertion
// sorted; then each merge pass merges pairs of runs into the scratch memory
// and copies them back, with about log2(n / run_size) passes. Results come
// out one at a time, each shown for one cycle under result_valid; the
// receiver cannot stall, so it must take every result as it appears. The
// memory reads are registered and the comparator is shared. Elements beyond
// 64 are dropped and overflow is high on every result of that set.
module run_merge_sort (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rms_pkg::DATA_W-1:0] value,
  input  logic                              last_in,
  input  logic                              cfg_write,
  input  logic [rms_pkg::RS_W-1:0]          cfg_data,
  output logic                              result_valid,
  output logic signed [rms_pkg::DATA_W-1:0] sorted_value,
  output logic                              last_out,
  output logic                              overflow
);

  localparam int CW = rms_pkg::CNT_W;
  localparam int RW = rms_pkg::RS_W;

  logic [RW-1:0] run_size;
  logic [CW-1:0] count;
  logic          dropped;
  logic          overflow_flag;

  logic               accept;
  logic               full;
  rms_pkg::load_t     load;
  rms_pkg::sort_cmd_t cmd;

  assign accept = start && !busy;
  assign full   = (count == CW'(rms_pkg::MAX_ELEMS));

  assign load.we   = accept && !full;
  assign load.addr = count[rms_pkg::ADDR_W-1:0];
  assign load.data = value;

  assign cmd.go = accept && last_in;
  assign cmd.n  = full ? count : count + 1'b1;
  assign cmd.rs = (run_size == '0) ? RW'(1) : run_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_size      <= RW'(rms_pkg::RS_RESET);
      count         <= '0;
      dropped       <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_write) begin
        run_size <= cfg_data;
      end
      if (accept) begin
        if (last_in) begin
          count         <= '0;
          dropped       <= 1'b0;
          overflow_flag <= dropped || full;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  rms_core u_core (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .last_out     (last_out)
  );

  assign overflow = overflow_flag;

`ifndef SYNTH
  a_result_when_busy : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside a sort");

  a_last_starts_sort : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_in) |=> busy)
    else $error("last transaction did not start a sort");

  a_last_is_result : assert property (@(posedge clk) disable iff (rst)
    last_out |-> result_valid)
    else $error("last_out without a result");

  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_out) |=> !busy)
    else $error("still busy after the final result");

  a_quiet_when_idle : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_in) |=> !result_valid)
    else $error("result after a loading transaction");
`endif

endmodule
